### hw/rtl/tgst_pkg.sv
// Shared types, codes and constants for the two-gate speed timer.
package tgst_pkg;

  // Default tick counter width
  localparam int COUNT_BITS_DEF = 32;

  // Input modes
  localparam logic [1:0] MODE_RESTART = 2'd0;
  localparam logic [1:0] MODE_GATE1   = 2'd1;
  localparam logic [1:0] MODE_GATE2   = 2'd2;
  localparam logic [1:0] MODE_TICK    = 2'd3;

  // Trap phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_ARMED  = 2'd1;
  localparam logic [1:0] PH_TIMING = 2'd2;
  localparam logic [1:0] PH_UNUSED = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 9;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GATE_DISTANCE = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRIP_LEVEL    = 1'd1;
  localparam logic [8:0] TRIP_LEVEL_RESET = 9'd230;

  // Voltage scaling: sample * 500 / 1023
  localparam int PROD_BITS = 19;
  localparam int VOLT_MUL  = 500;
  localparam int VOLT_DIV  = 1023;

  // Speed: distance * 156250 / (22 * ticks)
  localparam int SPEED_NUM    = 156250;
  localparam int NUM_BITS     = 26;
  localparam int DIV_STEPS    = NUM_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
  localparam int SPEED_BITS   = 21;

  typedef struct packed {
    logic [1:0] mode;
    logic [9:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [1:0]            phase;
    logic                  timing_lamp;
    logic [8:0]            scaled_volts;
    logic                  speed_valid;
    logic [SPEED_BITS-1:0] speed_hundredths;
    logic                  zero_time;
  } out_word_t;

  typedef enum logic [2:0] {
    CTL_IDLE,
    CTL_SCALE,
    CTL_UPDATE,
    CTL_DIV,
    CTL_DONE
  } ctl_state_e;

  typedef struct packed {
    logic load;
    logic scale;
    logic update;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_needed;
    logic div_last;
  } dp_sts_t;

endpackage

### hw/rtl/tgst_datapath.sv
// Datapath: configuration, trap state, voltage scaling and the serial divider.
module tgst_datapath #(
  parameter int COUNT_BITS = tgst_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tgst_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [tgst_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  tgst_pkg::in_word_t                  in_word_i,
  input  tgst_pkg::dp_cmd_t                   cmd_i,
  output tgst_pkg::dp_sts_t                   sts_o,
  output tgst_pkg::out_word_t                 out_word_o
);

  localparam int DW = COUNT_BITS + 5;
  localparam int PB = tgst_pkg::PROD_BITS;
  localparam int NB = tgst_pkg::NUM_BITS;

  logic [7:0]            gd_q;
  logic [8:0]            trip_q;
  logic [1:0]            phase_q, phase_d;
  logic [COUNT_BITS-1:0] tick_q, tick_d;
  logic [tgst_pkg::DIV_CNT_BITS-1:0] cnt_q;

  tgst_pkg::in_word_t    item_q;
  logic [PB-1:0]         prod_q;
  logic [8:0]            volts_q, volts_d;
  logic [1:0]            res_phase_q;
  logic                  res_valid_q, res_valid_d;
  logic                  res_zero_q, res_zero_d;
  logic [NB-1:0]         num_q;
  logic [DW-1:0]         den_q, den_d;
  logic [DW-1:0]         rem_q;
  logic [NB-1:0]         quot_q;
  tgst_pkg::out_word_t   out_q;

  logic [8:0]            q0;
  logic [PB-1:0]         q0_x;
  logic [PB-1:0]         resid;
  logic                  is_gate;
  logic [1:0]            ph_eff;
  logic                  tripped;
  logic [DW:0]           rem_sh;
  logic [DW:0]           rem_sub;
  logic                  rem_ge;

  // Scale: floor(p/1024) is at most one short of floor(p/1023)
  always_comb begin
    q0      = prod_q[PB-1:10];
    q0_x    = {q0, 10'b0} - {10'b0, q0};
    resid   = prod_q - q0_x;
    is_gate = (item_q.mode == tgst_pkg::MODE_GATE1) ||
              (item_q.mode == tgst_pkg::MODE_GATE2);
    if (is_gate) begin
      volts_d = q0 + {8'b0, (resid >= PB'(tgst_pkg::VOLT_DIV))};
    end else begin
      volts_d = '0;
    end
  end

  // Phase and counter update
  always_comb begin
    if (phase_q == tgst_pkg::PH_ARMED || phase_q == tgst_pkg::PH_TIMING) begin
      ph_eff = phase_q;
    end else begin
      ph_eff = tgst_pkg::PH_IDLE;
    end
    tripped     = volts_q > trip_q;
    phase_d     = ph_eff;
    tick_d      = tick_q;
    res_valid_d = 1'b0;
    res_zero_d  = 1'b0;
    case (item_q.mode)
      tgst_pkg::MODE_RESTART: begin
        if (ph_eff == tgst_pkg::PH_IDLE) phase_d = tgst_pkg::PH_ARMED;
      end
      tgst_pkg::MODE_GATE1: begin
        if (ph_eff == tgst_pkg::PH_ARMED && tripped) begin
          tick_d  = '0;
          phase_d = tgst_pkg::PH_TIMING;
        end
      end
      tgst_pkg::MODE_GATE2: begin
        if (ph_eff == tgst_pkg::PH_TIMING && tripped) begin
          res_valid_d = 1'b1;
          res_zero_d  = (tick_q == '0);
          phase_d     = tgst_pkg::PH_IDLE;
        end
      end
      tgst_pkg::MODE_TICK: begin
        // saturate at full scale
        if (ph_eff == tgst_pkg::PH_TIMING && tick_q != '1) tick_d = tick_q + 1'b1;
      end
      default: ;
    endcase
    den_d = (DW'(tick_q) << 4) + (DW'(tick_q) << 2) + (DW'(tick_q) << 1);
  end

  // Restoring division, one quotient bit per step
  always_comb begin
    rem_sh  = {rem_q, num_q[NB-1]};
    rem_ge  = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  assign sts_o.div_needed = res_valid_d && !res_zero_d;
  assign sts_o.div_last   = (cnt_q == tgst_pkg::DIV_CNT_BITS'(tgst_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gd_q    <= '0;
      trip_q  <= tgst_pkg::TRIP_LEVEL_RESET;
      phase_q <= tgst_pkg::PH_IDLE;
      tick_q  <= '0;
      cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tgst_pkg::CFG_GATE_DISTANCE: gd_q   <= cfg_data_i[7:0];
          tgst_pkg::CFG_TRIP_LEVEL:    trip_q <= cfg_data_i[8:0];
          default: ;
        endcase
      end
      if (cmd_i.update) begin
        phase_q <= phase_d;
        tick_q  <= tick_d;
        cnt_q   <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_word_i;
      prod_q <= PB'(in_word_i.sample) * PB'(tgst_pkg::VOLT_MUL);
    end
    if (cmd_i.scale) volts_q <= volts_d;
    if (cmd_i.update) begin
      res_phase_q <= phase_d;
      res_valid_q <= res_valid_d;
      res_zero_q  <= res_zero_d;
      num_q       <= NB'(gd_q) * NB'(tgst_pkg::SPEED_NUM);
      den_q       <= den_d;
      rem_q       <= '0;
      quot_q      <= '0;
    end else if (cmd_i.div_step) begin
      num_q  <= {num_q[NB-2:0], 1'b0};
      rem_q  <= rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      quot_q <= {quot_q[NB-2:0], rem_ge};
    end
    if (cmd_i.emit) begin
      out_q.phase            <= res_phase_q;
      out_q.timing_lamp      <= (res_phase_q == tgst_pkg::PH_TIMING);
      out_q.scaled_volts     <= volts_q;
      out_q.speed_valid      <= res_valid_q;
      out_q.speed_hundredths <= quot_q[tgst_pkg::SPEED_BITS-1:0];
      out_q.zero_time        <= res_zero_q;
    end
  end

  assign out_word_o = out_q;

`ifndef SYNTH
  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != tgst_pkg::PH_UNUSED)
    else $error("trap phase holds the unused code");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.update && phase_d == tgst_pkg::PH_TIMING && phase_q == tgst_pkg::PH_ARMED)
    |=> tick_q == '0)
    else $error("tick count not cleared when timing starts");

  a_quot_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> quot_q == '0)
    else $error("quotient not cleared at update");
`endif

endmodule

### hw/rtl/tgst_ctrl.sv
// Controller: sequences each word through scale, update, divide when needed, and output.
module tgst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  tgst_pkg::dp_sts_t sts_i,
  output tgst_pkg::dp_cmd_t cmd_o
);

  tgst_pkg::ctl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tgst_pkg::CTL_IDLE:   if (in_valid_i) state_d = tgst_pkg::CTL_SCALE;
      tgst_pkg::CTL_SCALE:  state_d = tgst_pkg::CTL_UPDATE;
      tgst_pkg::CTL_UPDATE: begin
        state_d = sts_i.div_needed ? tgst_pkg::CTL_DIV : tgst_pkg::CTL_DONE;
      end
      tgst_pkg::CTL_DIV:    if (sts_i.div_last) state_d = tgst_pkg::CTL_DONE;
      tgst_pkg::CTL_DONE:   if (out_free) state_d = tgst_pkg::CTL_IDLE;
      default:              state_d = tgst_pkg::CTL_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    case (state_q)
      tgst_pkg::CTL_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      tgst_pkg::CTL_SCALE:  cmd_o.scale    = 1'b1;
      tgst_pkg::CTL_UPDATE: cmd_o.update   = 1'b1;
      tgst_pkg::CTL_DIV:    cmd_o.div_step = 1'b1;
      tgst_pkg::CTL_DONE:   cmd_o.emit     = out_free;
      default: ;
    endcase
    // hold the word while stalled, drop it once taken
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tgst_pkg::CTL_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_accept_scales: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tgst_pkg::CTL_IDLE && in_valid_i) |=> state_q == tgst_pkg::CTL_SCALE)
    else $error("accepted word did not advance to scaling");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tgst_pkg::CTL_DIV && sts_i.div_last) |=> state_q == tgst_pkg::CTL_DONE)
    else $error("divider did not finish after its last step");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_q && state_q == tgst_pkg::CTL_IDLE)
    else $error("emitted word not presented");
`endif

endmodule

### hw/rtl/two_gate_speed_timer_top.sv
// Two-gate speed timer: input word in, one result word out per input word.
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i): each word is a restart
//   press, a gate one or gate two converter sample, or a 0.1 ms tick.
//   Output channel (out_valid_o / out_stall_i / out_word_o): one word per input
//   word, carrying phase, lamp, scaled volts and, at a gate two crossing, the
//   speed in hundredths of mph or the zero-time flag.
//   Configuration (cfg_we_i / cfg_idx_i / cfg_data_i): index 0 gate distance
//   (5.3 fixed inches), index 1 trip level; write only while idle.
// Sequence: each accepted word is scaled, then updates the trap, then is emitted;
//   a gate two crossing with a nonzero count first passes through the 26-step
//   restoring divider that produces one quotient bit per cycle.
// A new input word is accepted only after the previous word has been emitted.
// Reset: trap goes idle, tick count clears, gate distance 0, trip level 230.
// When the receiver stalls, the output word holds; the next input word is
//   still accepted and processed, and waits for the output register to free.
module two_gate_speed_timer_top #(
  parameter int COUNT_BITS = tgst_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tgst_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [tgst_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  tgst_pkg::in_word_t                 in_word_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output tgst_pkg::out_word_t                out_word_o
);

  tgst_pkg::dp_cmd_t cmd;
  tgst_pkg::dp_sts_t sts;

  tgst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tgst_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

endmodule

### tb/two_gate_speed_timer_top_test.sv
// Self-checking testbench for the two-gate speed timer: directed, back-to-back and random traps.
module two_gate_speed_timer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Counter width as built
  localparam int CNT_W        = tgst_pkg::COUNT_BITS_DEF;
  localparam int SPEED_DEN    = 22;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 2000000;

  class trap_checker;
    logic [7:0]          gate_dist;
    logic [8:0]          trip;
    logic [1:0]          phase;
    logic [CNT_W-1:0]    ticks;
    tgst_pkg::out_word_t readings_due[$];
    int                  errors;

    function new();
      gate_dist = '0;
      trip      = tgst_pkg::TRIP_LEVEL_RESET;
      phase     = tgst_pkg::PH_IDLE;
      ticks     = '0;
      errors    = 0;
    endfunction

    function void set_reg(logic [tgst_pkg::CFG_IDX_BITS-1:0] idx,
                          logic [tgst_pkg::CFG_DATA_BITS-1:0] data);
      if (idx == tgst_pkg::CFG_GATE_DISTANCE) gate_dist = data[7:0];
      else if (idx == tgst_pkg::CFG_TRIP_LEVEL) trip = data[8:0];
    endfunction

    // Advance the trap by one input word and queue the reading it must give
    function void note_word(tgst_pkg::in_word_t w);
      tgst_pkg::out_word_t r;
      int unsigned         volts;
      bit                  tripped;
      bit [63:0]           num;
      bit [63:0]           den;
      r = '0;
      volts = 0;
      if (phase == tgst_pkg::PH_UNUSED) phase = tgst_pkg::PH_IDLE;
      if (w.mode == tgst_pkg::MODE_GATE1 || w.mode == tgst_pkg::MODE_GATE2)
        volts = int'(w.sample) * tgst_pkg::VOLT_MUL / tgst_pkg::VOLT_DIV;
      tripped = volts > int'(trip);
      case (w.mode)
        tgst_pkg::MODE_RESTART: begin
          if (phase == tgst_pkg::PH_IDLE) phase = tgst_pkg::PH_ARMED;
        end
        tgst_pkg::MODE_GATE1: begin
          if (phase == tgst_pkg::PH_ARMED && tripped) begin
            ticks = '0;
            phase = tgst_pkg::PH_TIMING;
          end
        end
        tgst_pkg::MODE_GATE2: begin
          if (phase == tgst_pkg::PH_TIMING && tripped) begin
            r.speed_valid = 1'b1;
            if (ticks == '0) begin
              r.zero_time = 1'b1;
            end else begin
              num = 64'(gate_dist) * 64'(tgst_pkg::SPEED_NUM);
              den = 64'(SPEED_DEN) * 64'(ticks);
              r.speed_hundredths = tgst_pkg::SPEED_BITS'(num / den);
            end
            phase = tgst_pkg::PH_IDLE;
          end
        end
        default: begin
          if (phase == tgst_pkg::PH_TIMING && ticks != '1) ticks++;
        end
      endcase
      r.phase        = phase;
      r.timing_lamp  = (phase == tgst_pkg::PH_TIMING);
      r.scaled_volts = volts[8:0];
      readings_due.push_back(r);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(tgst_pkg::out_word_t got);
      tgst_pkg::out_word_t want;
      if (readings_due.size() == 0) begin
        $error("result word with no input word pending");
        errors++;
        return;
      end
      want = readings_due.pop_front();
      check_field("phase", want.phase, got.phase);
      check_field("timing_lamp", want.timing_lamp, got.timing_lamp);
      check_field("scaled_volts", want.scaled_volts, got.scaled_volts);
      check_field("speed_valid", want.speed_valid, got.speed_valid);
      check_field("speed_hundredths", want.speed_hundredths, got.speed_hundredths);
      check_field("zero_time", want.zero_time, got.zero_time);
    endfunction
  endclass

  logic                               clk;
  logic                               rst_n     = 1'b0;
  logic                               cfg_we    = 1'b0;
  logic [tgst_pkg::CFG_IDX_BITS-1:0]  cfg_idx   = '0;
  logic [tgst_pkg::CFG_DATA_BITS-1:0] cfg_data  = '0;
  logic                               in_valid  = 1'b0;
  logic                               in_stall;
  tgst_pkg::in_word_t                 in_word   = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  tgst_pkg::out_word_t                out_word;

  logic        idle_en = 1'b1;
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;
  trap_checker sb = new();

  two_gate_speed_timer_top #(
    .COUNT_BITS(CNT_W)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sample before the edge takes effect, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_word);
    out_stall <= idle_en && ($urandom_range(0, 99) < 24);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("two_gate_speed_timer_top test failed");
    $finish;
  end

  task automatic send_word(logic [1:0] mode, logic [9:0] sample);
    tgst_pkg::in_word_t w;
    w.mode   = mode;
    w.sample = sample;
    while (idle_en && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    sb.note_word(w);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.readings_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Only while idle: both registers, one per cycle
  task automatic write_regs(logic [8:0] dist_data, logic [8:0] trip_data);
    cfg_we   <= 1'b1;
    cfg_idx  <= tgst_pkg::CFG_GATE_DISTANCE;
    cfg_data <= dist_data;
    @(posedge clk);
    cfg_idx  <= tgst_pkg::CFG_TRIP_LEVEL;
    cfg_data <= trip_data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(tgst_pkg::CFG_GATE_DISTANCE, dist_data);
    sb.set_reg(tgst_pkg::CFG_TRIP_LEVEL, trip_data);
  endtask

  // Sample that trips (hit) or stays below the current trip level
  function automatic logic [9:0] pick_sample(bit hit);
    int unsigned first_trip;
    first_trip = ((int'(sb.trip) + 1) * tgst_pkg::VOLT_DIV + tgst_pkg::VOLT_MUL - 1) /
                 tgst_pkg::VOLT_MUL;
    if (first_trip > 1023) return 10'($urandom_range(0, 1023));
    if (hit) return 10'($urandom_range(first_trip, 1023));
    return 10'($urandom_range(0, first_trip - 1));
  endfunction

  task automatic run_measurement();
    int n_ticks;
    int pick;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4))
        send_word(2'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)));
    end
    send_word(tgst_pkg::MODE_RESTART, 10'($urandom_range(0, 1023)));
    if ($urandom_range(0, 3) == 0) send_word(tgst_pkg::MODE_GATE1, pick_sample(1'b0));
    send_word(tgst_pkg::MODE_GATE1, pick_sample(1'b1));
    pick = $urandom_range(0, 19);
    if (pick == 0) n_ticks = 0;
    else if (pick == 1) n_ticks = $urandom_range(100, 600);
    else n_ticks = $urandom_range(1, 20);
    repeat (n_ticks) begin
      send_word(tgst_pkg::MODE_TICK, 10'($urandom_range(0, 1023)));
      if ($urandom_range(0, 7) == 0) begin
        // stray words while timing: none of them may end the run
        case ($urandom_range(0, 2))
          0:       send_word(tgst_pkg::MODE_GATE1, 10'($urandom_range(0, 1023)));
          1:       send_word(tgst_pkg::MODE_RESTART, 10'($urandom_range(0, 1023)));
          default: send_word(tgst_pkg::MODE_GATE2, pick_sample(1'b0));
        endcase
      end
    end
    // now and then leave the trap timing
    if ($urandom_range(0, 9) == 0) return;
    send_word(tgst_pkg::MODE_GATE2, pick_sample(1'b1));
  endtask

  initial begin
    int unsigned goal;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: distance 0, trip level 230
    send_word(tgst_pkg::MODE_TICK, 10'd0);
    send_word(tgst_pkg::MODE_GATE2, 10'd1023);
    send_word(tgst_pkg::MODE_GATE1, 10'd1023);
    send_word(tgst_pkg::MODE_RESTART, 10'd0);
    send_word(tgst_pkg::MODE_RESTART, 10'd1023);
    send_word(tgst_pkg::MODE_GATE2, 10'd1023);
    send_word(tgst_pkg::MODE_GATE1, 10'd472);
    send_word(tgst_pkg::MODE_GATE1, 10'd473);
    send_word(tgst_pkg::MODE_TICK, 10'd1023);
    send_word(tgst_pkg::MODE_GATE1, 10'd1023);
    send_word(tgst_pkg::MODE_RESTART, 10'd0);
    send_word(tgst_pkg::MODE_GATE2, 10'd472);
    send_word(tgst_pkg::MODE_GATE2, 10'd473);
    drain();

    // Distance write with bit 8 set must mask to 255; trip level 0
    write_regs(9'h1FF, 9'd0);
    send_word(tgst_pkg::MODE_RESTART, 10'd0);
    send_word(tgst_pkg::MODE_GATE1, 10'd0);
    send_word(tgst_pkg::MODE_GATE1, 10'd3);
    send_word(tgst_pkg::MODE_GATE2, 10'd1023);
    send_word(tgst_pkg::MODE_RESTART, 10'd0);
    send_word(tgst_pkg::MODE_GATE1, 10'd1023);
    send_word(tgst_pkg::MODE_TICK, 10'd0);
    send_word(tgst_pkg::MODE_GATE2, 10'd1023);
    send_word(tgst_pkg::MODE_TICK, 10'd0);
    drain();

    // One long measurement with no idling on either side
    idle_en <= 1'b0;
    send_word(tgst_pkg::MODE_RESTART, 10'd0);
    send_word(tgst_pkg::MODE_GATE1, 10'd1023);
    repeat (100) send_word(tgst_pkg::MODE_TICK, 10'($urandom_range(0, 1023)));
    send_word(tgst_pkg::MODE_GATE2, 10'd1023);
    drain();
    idle_en <= 1'b1;

    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       write_regs(9'h100, 9'd511);
        1:       write_regs(9'd1, 9'd0);
        2:       write_regs(9'd255, 9'd500);
        3:       write_regs(9'd255, 9'd499);
        default: write_regs(9'($urandom_range(0, 511)), 9'($urandom_range(0, 450)));
      endcase
      // no gate can trip in the first and third setting, so keep those short
      goal = words_sent + ((p == 0 || p == 2) ? 40 : 160);
      while (words_sent < goal) run_measurement();
      drain();
    end

    if (sb.errors == 0) begin
      $display("two_gate_speed_timer_top test passed");
    end else begin
      $display("two_gate_speed_timer_top test failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/tgst_pkg.sv
hw/rtl/tgst_datapath.sv
hw/rtl/tgst_ctrl.sv
hw/rtl/two_gate_speed_timer_top.sv
tb/two_gate_speed_timer_top_test.sv
